### sv/elevator_call_controller_defines.svh
// Assertion macros for the elevator call controller.
// Included by the RTL files that carry concurrent assertions; needs clk_i and rst_ni in scope.
`ifndef ELEVATOR_CALL_CONTROLLER_DEFINES_SVH
`define ELEVATOR_CALL_CONTROLLER_DEFINES_SVH

// Checked on every rising edge outside of reset.
`define ECC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ECC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### sv/ecc_pkg.sv
// Shared constants and types of the elevator call controller.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ecc_pkg;

  localparam int unsigned FLOORS     = 10;
  localparam int unsigned COUNT_BITS = 8;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned FLOOR_W = 4;
  localparam int unsigned DIR_W   = 2;
  localparam int unsigned RIDER_W = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_HALL    = 2'd0,
    MODE_CAR     = 2'd1,
    MODE_SERVICE = 2'd2,
    MODE_NOP     = 2'd3
  } mode_e;

  typedef enum logic [DIR_W-1:0] {
    DIR_STOP = 2'd0,
    DIR_DOWN = 2'd1,
    DIR_UP   = 2'd2
  } dir_e;

endpackage

`default_nettype wire

### sv/ecc_req_if.sv
// Request channel of the elevator call controller: valid/ready plus event payload.
// Depends on ecc_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ecc_req_if;
  logic                         valid;
  logic                         ready;
  logic [ecc_pkg::MODE_W-1:0]   mode;
  logic [ecc_pkg::FLOOR_W-1:0]  floor;

  modport source (output valid, output mode, output floor, input ready);
  modport sink   (input valid, input mode, input floor, output ready);
endinterface

`default_nettype wire

### sv/ecc_res_if.sv
// Result channel of the elevator call controller: valid/ready plus result payload.
// Depends on ecc_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface ecc_res_if;
  logic                         valid;
  logic                         ready;
  logic [ecc_pkg::FLOOR_W-1:0]  car_floor_now;
  logic [ecc_pkg::DIR_W-1:0]    direction_now;
  logic [ecc_pkg::RIDER_W-1:0]  riders_boarding;
  logic [ecc_pkg::RIDER_W-1:0]  riders_leaving;
  logic                         floor_served;

  modport source (output valid, output car_floor_now, output direction_now,
                  output riders_boarding, output riders_leaving, output floor_served,
                  input ready);
  modport sink   (input valid, input car_floor_now, input direction_now,
                  input riders_boarding, input riders_leaving, input floor_served,
                  output ready);
endinterface

`default_nettype wire

### sv/elevator_call_controller.sv
// Elevator call controller: call bits, car floor and direction in flops,
// rider counts in a synchronous memory. Depends on ecc_pkg, ecc_req_if, ecc_res_if
// and the assertion macros in elevator_call_controller_defines.svh.
//
//   channel  direction  payload
//   req_i    in         mode, floor
//   res_o    out        car_floor_now, direction_now, riders_boarding,
//                       riders_leaving, floor_served
//
// A request is accepted in ST_IDLE, which picks the target floor and reads its
// count entry; ST_RMW modifies and writes the entry back and loads the result
// register. The split follows from the registered read of the count memory.
// A new request is taken while a result still waits.
// Reset clears call bits, car floor and direction at once; a count entry whose
// call bit is low reads as zero, so the count memory needs no clearing pass.
// A stalled result holds the write-back cycle until the result register frees.
`timescale 1ns / 1ps
`default_nettype none

`include "elevator_call_controller_defines.svh"

module elevator_call_controller #(
  parameter int unsigned FLOORS     = ecc_pkg::FLOORS,
  parameter int unsigned COUNT_BITS = ecc_pkg::COUNT_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ecc_req_if.sink     req_i,
  ecc_res_if.source   res_o
);

  localparam int unsigned FloorW = (FLOORS > 1) ? $clog2(FLOORS) : 1;
  localparam int unsigned MemW   = 2 * COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RMW  = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [FLOORS-1:0] call_q, call_d;
  logic [FloorW-1:0] car_q, car_d;
  ecc_pkg::dir_e     dir_q, dir_d;

  // Operation latched at accept, consumed in the write-back cycle.
  logic [FloorW-1:0] addr_q;
  logic              op_hall_q, op_car_q, op_serve_q, rd_valid_q;

  logic [MemW-1:0]   mem [FLOORS];
  logic [MemW-1:0]   rd_q;
  logic [MemW-1:0]   wdata;
  logic              mem_we;

  logic                          out_valid_q;
  logic [ecc_pkg::FLOOR_W-1:0]   out_floor_q;
  logic [ecc_pkg::DIR_W-1:0]     out_dir_q;
  logic [ecc_pkg::RIDER_W-1:0]   out_board_q, out_leave_q;
  logic                          out_served_q;

  logic              accept, advance, floor_ok;
  logic [FloorW-1:0] req_idx, rd_addr;
  logic              up_found, down_found, here_called, svc_hit;
  logic [FloorW-1:0] up_idx, down_idx, svc_tgt;
  ecc_pkg::dir_e     svc_dir;
  logic [COUNT_BITS-1:0] cur_board, cur_leave;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign advance     = (state_q == ST_RMW) && (!out_valid_q || res_o.ready);
  assign floor_ok    = (32'(req_i.floor) < FLOORS);
  assign req_idx     = FloorW'(req_i.floor);

  // Nearest pending call above and below the car.
  always_comb begin
    up_found   = 1'b0;
    up_idx     = '0;
    down_found = 1'b0;
    down_idx   = '0;
    for (int i = int'(FLOORS) - 1; i >= 0; i--) begin
      if (call_q[i] && (i > int'(car_q))) begin
        up_found = 1'b1;
        up_idx   = FloorW'(i);
      end
    end
    for (int i = 0; i < int'(FLOORS); i++) begin
      if (call_q[i] && (i < int'(car_q))) begin
        down_found = 1'b1;
        down_idx   = FloorW'(i);
      end
    end
  end

  assign here_called = call_q[car_q];

  always_comb begin
    svc_hit = 1'b1;
    svc_tgt = car_q;
    svc_dir = dir_q;
    if (here_called) begin
      svc_dir = ecc_pkg::DIR_STOP;
    end else if (up_found && down_found) begin
      // Calls on both sides: keep going down, otherwise go up.
      if (dir_q == ecc_pkg::DIR_DOWN) begin
        svc_tgt = down_idx;
      end else begin
        svc_dir = ecc_pkg::DIR_UP;
        svc_tgt = up_idx;
      end
    end else if (up_found) begin
      svc_dir = ecc_pkg::DIR_UP;
      svc_tgt = up_idx;
    end else if (down_found) begin
      svc_dir = ecc_pkg::DIR_DOWN;
      svc_tgt = down_idx;
    end else begin
      svc_hit = 1'b0;
    end
  end

  assign rd_addr = (ecc_pkg::mode_e'(req_i.mode) == ecc_pkg::MODE_SERVICE) ? svc_tgt : req_idx;

  always_comb begin
    call_d  = call_q;
    car_d   = car_q;
    dir_d   = dir_q;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RMW;
          case (ecc_pkg::mode_e'(req_i.mode))
            ecc_pkg::MODE_HALL, ecc_pkg::MODE_CAR: begin
              if (floor_ok) call_d[req_idx] = 1'b1;
            end
            ecc_pkg::MODE_SERVICE: begin
              if (svc_hit) begin
                call_d[svc_tgt] = 1'b0;
                car_d           = svc_tgt;
                dir_d           = svc_dir;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RMW: begin
        if (advance) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      call_q     <= '0;
      car_q      <= '0;
      dir_q      <= ecc_pkg::DIR_STOP;
      op_hall_q  <= 1'b0;
      op_car_q   <= 1'b0;
      op_serve_q <= 1'b0;
      rd_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      call_q  <= call_d;
      car_q   <= car_d;
      dir_q   <= dir_d;
      if (accept) begin
        op_hall_q  <= (ecc_pkg::mode_e'(req_i.mode) == ecc_pkg::MODE_HALL) && floor_ok;
        op_car_q   <= (ecc_pkg::mode_e'(req_i.mode) == ecc_pkg::MODE_CAR) && floor_ok;
        op_serve_q <= (ecc_pkg::mode_e'(req_i.mode) == ecc_pkg::MODE_SERVICE) && svc_hit;
        rd_valid_q <= call_q[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) addr_q <= rd_addr;
  end

  // An entry whose call bit was low holds stale data and counts as zero.
  assign cur_board = rd_valid_q ? rd_q[MemW-1:COUNT_BITS] : '0;
  assign cur_leave = rd_valid_q ? rd_q[COUNT_BITS-1:0]    : '0;

  assign mem_we = advance && (op_hall_q || op_car_q || op_serve_q);

  always_comb begin
    wdata = '0;
    if (op_hall_q) begin
      wdata = {((cur_board == CountMax) ? cur_board : cur_board + COUNT_BITS'(1)), cur_leave};
    end else if (op_car_q) begin
      wdata = {cur_board, ((cur_leave == CountMax) ? cur_leave : cur_leave + COUNT_BITS'(1))};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[addr_q] <= wdata;
    if (accept) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_floor_q  <= ecc_pkg::FLOOR_W'(car_q);
      out_dir_q    <= dir_q;
      out_board_q  <= op_serve_q ? ecc_pkg::RIDER_W'(cur_board) : '0;
      out_leave_q  <= op_serve_q ? ecc_pkg::RIDER_W'(cur_leave) : '0;
      out_served_q <= op_serve_q;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.car_floor_now   = out_floor_q;
  assign res_o.direction_now   = out_dir_q;
  assign res_o.riders_boarding = out_board_q;
  assign res_o.riders_leaving  = out_leave_q;
  assign res_o.floor_served    = out_served_q;

  `ECC_ASSERT(a_accept_enters_rmw, accept |=> (state_q == ST_RMW),
              "accepted request did not enter write-back")
  `ECC_ASSERT(a_write_only_in_rmw, mem_we |-> (state_q == ST_RMW),
              "count memory written outside write-back")
  `ECC_ASSERT(a_serve_moves_car,
              (accept && (ecc_pkg::mode_e'(req_i.mode) == ecc_pkg::MODE_SERVICE) && svc_hit)
              |=> (!call_q[addr_q] && (car_q == addr_q)),
              "served floor not reached or call not cleared")
  `ECC_ASSERT(a_unserved_no_riders,
              (res_o.valid && !res_o.floor_served)
              |-> ((res_o.riders_boarding == '0) && (res_o.riders_leaving == '0)),
              "riders reported without a served floor")
  // The car register may still be unknown at the first edges while reset is low.
  `ECC_ASSERT_ALWAYS(a_car_in_range, (!rst_ni || (32'(car_q) < FLOORS)),
                     "car floor out of range")

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench of elevator_call_controller: a short scripted call sequence,
// then random call bursts and service steps, checked against an in-bench car model.
// Depends on ecc_pkg, ecc_req_if, ecc_res_if and the controller RTL.
`timescale 1ns / 1ps

module tb;
  import ecc_pkg::*;

  localparam int unsigned EVENT_TARGET = 1700;
  localparam int unsigned CALM_AFTER   = 1550;
  localparam int unsigned HOLD_AT      = 900;
  localparam int unsigned RUSH_AT      = 300;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned SETTLE       = 8;

  typedef struct packed {
    logic [FLOOR_W-1:0] car_floor;
    dir_e               dir;
    logic [RIDER_W-1:0] boarding;
    logic [RIDER_W-1:0] leaving;
    logic               served;
  } ride_result_t;

  typedef struct {
    mode_e              mode;
    logic [FLOOR_W-1:0] floor;
    bit                 typed;
    ride_result_t       want;
  } script_row_t;

  localparam ride_result_t AT_LOBBY     = '{4'd0, DIR_STOP, 8'd0, 8'd0, 1'b0};
  localparam ride_result_t SERVED_LOBBY = '{4'd0, DIR_STOP, 8'd1, 8'd0, 1'b1};

  // Rows that are not typed are checked against the car model.
  script_row_t opening_script [24] = '{
    '{MODE_SERVICE, 4'd0,  1'b1, AT_LOBBY},      // no calls after reset
    '{MODE_NOP,     4'd15, 1'b1, AT_LOBBY},
    '{MODE_HALL,    4'd15, 1'b1, AT_LOBBY},      // floor out of range
    '{MODE_CAR,     4'd10, 1'b1, AT_LOBBY},
    '{MODE_HALL,    4'd0,  1'b1, AT_LOBBY},
    '{MODE_SERVICE, 4'd7,  1'b1, SERVED_LOBBY},  // current floor called
    '{MODE_HALL,    4'd9,  1'b0, AT_LOBBY},
    '{MODE_CAR,     4'd9,  1'b0, AT_LOBBY},
    '{MODE_SERVICE, 4'd0,  1'b0, AT_LOBBY},      // calls above only
    '{MODE_CAR,     4'd3,  1'b0, AT_LOBBY},
    '{MODE_HALL,    4'd6,  1'b0, AT_LOBBY},
    '{MODE_SERVICE, 4'd0,  1'b0, AT_LOBBY},      // calls below only
    '{MODE_CAR,     4'd8,  1'b0, AT_LOBBY},
    '{MODE_SERVICE, 4'd0,  1'b0, AT_LOBBY},      // both sides, keeps going down
    '{MODE_HALL,    4'd3,  1'b0, AT_LOBBY},
    '{MODE_SERVICE, 4'd0,  1'b0, AT_LOBBY},      // stops where it stands
    '{MODE_HALL,    4'd1,  1'b0, AT_LOBBY},
    '{MODE_SERVICE, 4'd0,  1'b0, AT_LOBBY},      // stopped with calls both sides: up
    '{MODE_SERVICE, 4'd0,  1'b0, AT_LOBBY},
    '{MODE_SERVICE, 4'd0,  1'b0, AT_LOBBY},      // nothing left to serve
    '{MODE_NOP,     4'd0,  1'b0, AT_LOBBY},
    '{MODE_CAR,     4'd5,  1'b0, AT_LOBBY},
    '{MODE_HALL,    4'd10, 1'b0, AT_LOBBY},
    '{MODE_SERVICE, 4'd15, 1'b0, AT_LOBBY}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ecc_req_if req();
  ecc_res_if res();

  elevator_call_controller dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .res_o  (res)
  );

  always #1 clk_i = ~clk_i;

  // Car model state.
  bit                    call_on    [FLOORS];
  logic [COUNT_BITS-1:0] board_cnt  [FLOORS];
  logic [COUNT_BITS-1:0] alight_cnt [FLOORS];
  logic [FLOOR_W-1:0]    car_at;
  dir_e                  heading;

  ride_result_t reports_due [$];
  bit           row_typed;
  ride_result_t row_want;

  int  mismatches   = 0;
  int  events_sent  = 0;
  int  requests_in  = 0;
  int  reports_seen = 0;
  int  floors_hit   = 0;
  int  full_counts  = 0;
  int  send_idle_pct = 10;
  int  take_idle_pct = 10;
  bit  idling_off   = 1'b0;

  function automatic ride_result_t advance_car_model(mode_e m, logic [FLOOR_W-1:0] f);
    ride_result_t r;
    int above, below, target;
    above = -1;
    below = -1;
    target = -1;
    r = AT_LOBBY;
    if ((m == MODE_HALL || m == MODE_CAR) && f < FLOORS) begin
      call_on[f] = 1'b1;
      if (m == MODE_HALL) begin
        if (board_cnt[f] != '1) board_cnt[f]++;
      end else if (alight_cnt[f] != '1) begin
        alight_cnt[f]++;
      end
    end else if (m == MODE_SERVICE) begin
      // Scanning toward the car leaves the nearest call in each direction.
      for (int i = FLOORS - 1; i > car_at; i--) if (call_on[i]) above = i;
      for (int i = 0; i < car_at; i++) if (call_on[i]) below = i;
      if (call_on[car_at]) begin
        heading = DIR_STOP;
        target = car_at;
      end else if (above >= 0 && below >= 0) begin
        if (heading == DIR_DOWN) begin
          target = below;
        end else begin
          heading = DIR_UP;
          target = above;
        end
      end else if (above >= 0) begin
        heading = DIR_UP;
        target = above;
      end else if (below >= 0) begin
        heading = DIR_DOWN;
        target = below;
      end
      if (target >= 0) begin
        car_at = FLOOR_W'(target);
        call_on[target] = 1'b0;
        r.boarding = RIDER_W'(board_cnt[target]);
        r.leaving = RIDER_W'(alight_cnt[target]);
        board_cnt[target] = '0;
        alight_cnt[target] = '0;
        r.served = 1'b1;
      end
    end
    r.car_floor = car_at;
    r.dir = heading;
    return r;
  endfunction

  task automatic flag_field(string what, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("t=%0t %s mismatch: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Results are checked before the request of the same edge is predicted.
  always @(posedge clk_i) begin : watch
    ride_result_t got, want;
    if (res.valid === 1'b1 && res.ready === 1'b1) begin
      got = '{res.car_floor_now, dir_e'(res.direction_now), res.riders_boarding,
              res.riders_leaving, res.floor_served};
      reports_seen++;
      if (got.served) floors_hit++;
      if (got.boarding == '1 && got.leaving == '1) full_counts++;
      if (reports_due.size() == 0) begin
        mismatches++;
        $display("t=%0t unexpected result: floor %0d dir %0d board %0d leave %0d served %0d",
                 $time, got.car_floor, got.dir, got.boarding, got.leaving, got.served);
      end else begin
        want = reports_due.pop_front();
        flag_field("car_floor_now", want.car_floor, got.car_floor);
        flag_field("direction_now", want.dir, got.dir);
        flag_field("riders_boarding", want.boarding, got.boarding);
        flag_field("riders_leaving", want.leaving, got.leaving);
        flag_field("floor_served", want.served, got.served);
      end
    end
    if (req.valid === 1'b1 && req.ready === 1'b1) begin
      want = advance_car_model(mode_e'(req.mode), req.floor);
      reports_due.push_back(row_typed ? row_want : want);
      requests_in++;
    end
  end

  task automatic send_event(mode_e m, logic [FLOOR_W-1:0] f, bit typed = 1'b0,
                            ride_result_t want = AT_LOBBY);
    int gap;
    if (!idling_off && $urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 18);
      @(negedge clk_i);
      req.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req.valid <= 1'b1;
    req.mode <= m;
    req.floor <= f;
    row_typed = typed;
    row_want = want;
    do @(posedge clk_i); while (req.ready !== 1'b1);
    if (m == MODE_SERVICE || ((m == MODE_HALL || m == MODE_CAR) && f < FLOORS))
      events_sent++;
  endtask

  // Result side: stall bursts while idling is on.
  initial begin : taker
    int stall;
    res.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!idling_off && $urandom_range(0, 99) < take_idle_pct) begin
        stall = $urandom_range(1, 18);
        res.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
        @(negedge clk_i);
      end
      res.ready <= 1'b1;
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("t=%0t timeout with %0d results outstanding", $time, reports_due.size());
    $display("[elevator_call_controller] ERROR");
    $finish;
  end

  initial begin : stimulus
    int calls, steps, rush_floor;
    bit rushed, held;
    rushed = 1'b0;
    held = 1'b0;
    req.valid = 1'b0;
    req.mode = MODE_NOP;
    req.floor = '0;
    row_typed = 1'b0;
    row_want = AT_LOBBY;
    for (int i = 0; i < FLOORS; i++) begin
      call_on[i] = 1'b0;
      board_cnt[i] = '0;
      alight_cnt[i] = '0;
    end
    car_at = '0;
    heading = DIR_STOP;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (opening_script[i])
      send_event(opening_script[i].mode, opening_script[i].floor,
                 opening_script[i].typed, opening_script[i].want);

    while (events_sent < EVENT_TARGET) begin
      if ($urandom_range(0, 29) == 0) begin
        case ($urandom_range(0, 2))
          0: begin send_idle_pct = 0;  take_idle_pct = 0;  end
          1: begin send_idle_pct = 10; take_idle_pct = 15; end
          default: begin send_idle_pct = 35; take_idle_pct = 35; end
        endcase
      end
      if (events_sent >= CALM_AFTER) idling_off = 1'b1;

      if (!rushed && events_sent >= RUSH_AT) begin
        // Drive both counts of one floor past their maximum, then serve it.
        rushed = 1'b1;
        rush_floor = $urandom_range(0, FLOORS - 1);
        repeat (265) send_event(MODE_HALL, FLOOR_W'(rush_floor));
        repeat (265) send_event(MODE_CAR, FLOOR_W'(rush_floor));
        repeat (FLOORS + 1) send_event(MODE_SERVICE, FLOOR_W'($urandom_range(0, 15)));
      end else if (!held && events_sent >= HOLD_AT) begin
        held = 1'b1;
        @(negedge clk_i);
        req.valid <= 1'b0;
        while (reports_due.size() != 0) @(negedge clk_i);
      end else if ($urandom_range(0, 99) < 85) begin
        calls = $urandom_range(1, 6);
        steps = $urandom_range(1, 4);
        repeat (calls)
          send_event($urandom_range(0, 1) ? MODE_CAR : MODE_HALL,
                     FLOOR_W'($urandom_range(0, FLOORS - 1)));
        repeat (steps) send_event(MODE_SERVICE, FLOOR_W'($urandom_range(0, 15)));
      end else begin
        send_event(mode_e'($urandom_range(0, 3)), FLOOR_W'($urandom_range(0, 15)));
      end
    end

    @(negedge clk_i);
    req.valid <= 1'b0;
    while (reports_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);

    $display("Checked %0d results against %0d requests (%0d counted calls and steps).",
             reports_seen, requests_in, events_sent);
    $display("%0d service steps served a floor; %0d released both counts at their maximum.",
             floors_hit, full_counts);
    if (mismatches == 0)
      $display("[elevator_call_controller] OK");
    else
      $display("[elevator_call_controller] ERROR");
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/ecc_pkg.sv
sv/ecc_req_if.sv
sv/ecc_res_if.sv
sv/elevator_call_controller.sv
tb/tb.sv
